// File: rtl/mbce_pkg.sv
// Shared types and constants for the monochrome color-expansion blitter.
// Used by every module of the block; depends on nothing else.
package mbce_pkg;

  // Largest rectangle side; larger requests are clamped to it.
  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);

  // Fixed field widths of the item and result streams.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ADDR_W  = 32;

  // Input item kinds carried on the op bit.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_BITMAP = 1'b1;

  // One classified item, as it travels from the front end to the back end.
  typedef struct packed {
    logic                 is_start;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [DIM_W-1:0]     rect_width;
    logic [DIM_W-1:0]     rect_height;
    logic [COLOR_W-1:0]   color_fg;
    logic [COLOR_W-1:0]   color_bg;
    logic [7:0]           pixel_bits;
    logic                 nonempty;
  } mbce_item_t;

  // Configuration register values seen by the back end.
  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [15:0]       line_pitch;
    logic [2:0]        bytes_per_pixel;
    logic [1:0]        blue_lane;
    logic [1:0]        green_lane;
    logic [1:0]        red_lane;
  } mbce_cfg_t;

endpackage

// File: rtl/mbce_front.sv
// Front end: input register stage that accepts items, clamps the rectangle
// size and marks empty rectangles. Depends on mbce_pkg.
module mbce_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [11:0]             start_x,
  input  logic [11:0]             start_y,
  input  logic [12:0]             rect_width,
  input  logic [12:0]             rect_height,
  input  logic [23:0]             color_fg,
  input  logic [23:0]             color_bg,
  input  logic [7:0]              pixel_bits,
  output logic                    item_valid,
  input  logic                    item_ready,
  output mbce_pkg::mbce_item_t    item
);
  import mbce_pkg::*;

  logic       stage_v_r;
  logic       stage_v_nxt;
  mbce_item_t stage_item_r;
  mbce_item_t stage_item_nxt;
  logic [DIM_W-1:0] w_clamp;
  logic [DIM_W-1:0] h_clamp;

  assign in_ready   = !stage_v_r || item_ready;
  assign item_valid = stage_v_r;
  assign item       = stage_item_r;

  // Clamp oversized sides and classify the item.
  always_comb begin
    w_clamp = (rect_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_width;
    h_clamp = (rect_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_height;
    stage_item_nxt = stage_item_r;
    stage_v_nxt    = stage_v_r && !item_ready;
    if (in_valid && in_ready) begin
      stage_v_nxt                = 1'b1;
      stage_item_nxt.is_start    = (op == OP_START);
      stage_item_nxt.start_x     = start_x;
      stage_item_nxt.start_y     = start_y;
      stage_item_nxt.rect_width  = w_clamp;
      stage_item_nxt.rect_height = h_clamp;
      stage_item_nxt.color_fg    = color_fg;
      stage_item_nxt.color_bg    = color_bg;
      stage_item_nxt.pixel_bits  = pixel_bits;
      stage_item_nxt.nonempty    = (w_clamp != '0) && (h_clamp != '0);
    end
  end

  // Stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    stage_item_r <= stage_item_nxt;
  end

endmodule

// File: rtl/mbce_queue.sv
// Two-entry queue between the front end and the back end, so that each
// side can stall on its own. Depends on mbce_pkg.
module mbce_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  mbce_pkg::mbce_item_t    push_item,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output mbce_pkg::mbce_item_t    pop_item
);
  import mbce_pkg::*;

  mbce_item_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/mbce_back.sv
// Back end: latches rectangles, walks bitmap bits and emits one pixel write
// per cycle into the output register while it is free. Depends on mbce_pkg.
module mbce_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbce_pkg::mbce_cfg_t     cfg,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  mbce_pkg::mbce_item_t    q_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             write_address,
  output logic [31:0]             write_data,
  output logic [3:0]              byte_enable,
  output logic                    last,
  output logic                    done_res
);
  import mbce_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_PIX
  } state_t;

  state_t state_r, state_nxt;
  logic   active_r, active_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt;
  logic [ADDR_W-1:0]  pix_addr_r, pix_addr_nxt;
  logic [27:0]        prod_y_r, prod_y_nxt;
  logic [14:0]        prod_x_r, prod_x_nxt;
  logic [7:0]         bits_r, bits_nxt;
  logic [2:0]         k_r, k_nxt;

  logic [31:0] oaddr_r, oaddr_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [3:0]  oen_r, oen_nxt;
  logic        olast_r, olast_nxt;
  logic        odone_r, odone_nxt;

  logic              out_free;
  logic              emit;
  logic [7:0]        cur_bits;
  logic [2:0]        cur_k;
  logic [COLOR_W-1:0] color;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;
  logic              row_end;
  logic              rect_end;
  logic              last_pix;
  logic [31:0]       lane_data;
  logic [3:0]        lane_en;

  assign out_valid     = out_valid_r;
  assign write_address = oaddr_r;
  assign write_data    = odata_r;
  assign byte_enable   = oen_r;
  assign last          = olast_r;
  assign done_res      = odone_r;

  // Pixel selection and end-of-row / end-of-rectangle detection.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    emit     = out_free && ((state_r == S_PIX) ||
               ((state_r == S_IDLE) && q_valid && !q_item.is_start && active_r));
    q_ready  = (state_r == S_IDLE) && (q_item.is_start || !active_r || out_free);
    cur_bits = (state_r == S_PIX) ? bits_r : q_item.pixel_bits;
    cur_k    = (state_r == S_PIX) ? k_r : 3'd0;
    color    = cur_bits[7] ? fg_r : bg_r;
    col_inc  = col_r + DIM_W'(1);
    row_inc  = row_r + DIM_W'(1);
    row_end  = (col_inc >= width_r);
    rect_end = row_end && (row_inc >= height_r);
    last_pix = rect_end || (cur_k == 3'd7);
  end

  // Place the color bytes in their lanes; red beats green, green beats blue.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_en[i] = (cfg.red_lane == 2'(i)) || (cfg.green_lane == 2'(i)) ||
                   (cfg.blue_lane == 2'(i));
      if (cfg.red_lane == 2'(i)) begin
        lane_data[i*8 +: 8] = color[23:16];
      end else if (cfg.green_lane == 2'(i)) begin
        lane_data[i*8 +: 8] = color[15:8];
      end else if (cfg.blue_lane == 2'(i)) begin
        lane_data[i*8 +: 8] = color[7:0];
      end else begin
        lane_data[i*8 +: 8] = 8'd0;
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_ready;
    col_nxt       = col_r;
    row_nxt       = row_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    row_addr_nxt  = row_addr_r;
    pix_addr_nxt  = pix_addr_r;
    prod_y_nxt    = prod_y_r;
    prod_x_nxt    = prod_x_r;
    bits_nxt      = bits_r;
    k_nxt         = k_r;
    oaddr_nxt     = oaddr_r;
    odata_nxt     = odata_r;
    oen_nxt       = oen_r;
    olast_nxt     = olast_r;
    odone_nxt     = odone_r;

    case (state_r)
      S_IDLE: begin
        // A start item latches the rectangle and forms the origin products.
        if (q_valid && q_item.is_start) begin
          width_nxt  = q_item.rect_width;
          height_nxt = q_item.rect_height;
          fg_nxt     = q_item.color_fg;
          bg_nxt     = q_item.color_bg;
          col_nxt    = '0;
          row_nxt    = '0;
          active_nxt = q_item.nonempty;
          prod_y_nxt = cfg.line_pitch * q_item.start_y;
          prod_x_nxt = cfg.bytes_per_pixel * q_item.start_x;
          state_nxt  = S_ADD;
        end
      end
      S_ADD: begin
        row_addr_nxt = cfg.base_address + {4'd0, prod_y_r} + {17'd0, prod_x_r};
        pix_addr_nxt = cfg.base_address + {4'd0, prod_y_r} + {17'd0, prod_x_r};
        state_nxt    = S_IDLE;
      end
      S_PIX: begin
        state_nxt = S_PIX;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One pixel write per cycle while the output register can take it.
    if (emit) begin
      out_valid_nxt = 1'b1;
      oaddr_nxt     = pix_addr_r;
      odata_nxt     = lane_data;
      oen_nxt       = lane_en;
      olast_nxt     = last_pix;
      odone_nxt     = rect_end;
      bits_nxt      = {cur_bits[6:0], 1'b0};
      k_nxt         = cur_k + 3'd1;
      if (row_end) begin
        col_nxt      = '0;
        row_nxt      = row_inc;
        row_addr_nxt = row_addr_r + {16'd0, cfg.line_pitch};
        pix_addr_nxt = row_addr_r + {16'd0, cfg.line_pitch};
      end else begin
        col_nxt      = col_inc;
        pix_addr_nxt = pix_addr_r + {29'd0, cfg.bytes_per_pixel};
      end
      if (rect_end) begin
        active_nxt = 1'b0;
      end
      state_nxt = last_pix ? S_IDLE : S_PIX;
    end
  end

  // State and registered outputs; control state is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    fg_r       <= fg_nxt;
    bg_r       <= bg_nxt;
    row_addr_r <= row_addr_nxt;
    pix_addr_r <= pix_addr_nxt;
    prod_y_r   <= prod_y_nxt;
    prod_x_r   <= prod_x_nxt;
    bits_r     <= bits_nxt;
    k_r        <= k_nxt;
    oaddr_r    <= oaddr_nxt;
    odata_r    <= odata_nxt;
    oen_r      <= oen_nxt;
    olast_r    <= olast_nxt;
    odone_r    <= odone_nxt;
  end

endmodule

// File: rtl/mono_bitmap_color_expand_blit.sv
// Top level of the monochrome color-expansion blitter: configuration
// registers and the front end, queue and back end. Depends on mbce_pkg.
//
// A start item latches a rectangle and yields no pixel; each following bitmap
// byte yields one pixel write per bit, most significant bit first, until the
// rectangle is complete. The back end emits one pixel write per cycle while the
// output is not stalled; a start item passes through the origin multiply and
// then the address add, and a byte arriving with no active rectangle is dropped.
// A two-entry queue lets the input keep flowing while the output is stalled.
// Registers may be changed only while no transfer is in flight; an active
// rectangle uses the current pitch, pixel size and lanes for each pixel.
module mono_bitmap_color_expand_blit (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: start_x[11:0], start_y[11:0], rect_width[12:0],
  // rect_height[12:0], color_fg[23:0], color_bg[23:0], pixel_bits[7:0], zero pad
  input  logic [111:0] in_tdata,
  // tuser: op
  input  logic         in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: write_address[31:0], write_data[31:0], byte_enable[3:0],
  // zero pad
  output logic [71:0]  out_tdata,
  // tlast: last pixel of this byte
  output logic         out_tlast,
  // tuser: done_res
  output logic         out_tuser,
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import mbce_pkg::*;

  typedef enum logic [2:0] {
    REG_BASE  = 3'd0,
    REG_PITCH = 3'd1,
    REG_BPP   = 3'd2,
    REG_BLUE  = 3'd3,
    REG_GREEN = 3'd4,
    REG_RED   = 3'd5
  } reg_idx_t;

  mbce_cfg_t  cfg_r;
  logic [2:0] reg_sel;
  logic       cfg_wr;

  logic       f_valid;
  logic       f_ready;
  mbce_item_t f_item;
  logic       q_valid;
  logic       q_ready;
  mbce_item_t q_item;

  logic [31:0] wr_address;
  logic [31:0] wr_data;
  logic [3:0]  wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address    <= 32'd0;
      cfg_r.line_pitch      <= 16'd4096;
      cfg_r.bytes_per_pixel <= 3'd4;
      cfg_r.blue_lane       <= 2'd0;
      cfg_r.green_lane      <= 2'd1;
      cfg_r.red_lane        <= 2'd2;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BASE:  cfg_r.base_address    <= cfg_pwdata;
        REG_PITCH: cfg_r.line_pitch      <= cfg_pwdata[15:0];
        REG_BPP:   cfg_r.bytes_per_pixel <= cfg_pwdata[2:0];
        REG_BLUE:  cfg_r.blue_lane       <= cfg_pwdata[1:0];
        REG_GREEN: cfg_r.green_lane      <= cfg_pwdata[1:0];
        REG_RED:   cfg_r.red_lane        <= cfg_pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_sel)
      REG_BASE:  cfg_prdata = cfg_r.base_address;
      REG_PITCH: cfg_prdata = {16'd0, cfg_r.line_pitch};
      REG_BPP:   cfg_prdata = {29'd0, cfg_r.bytes_per_pixel};
      REG_BLUE:  cfg_prdata = {30'd0, cfg_r.blue_lane};
      REG_GREEN: cfg_prdata = {30'd0, cfg_r.green_lane};
      REG_RED:   cfg_prdata = {30'd0, cfg_r.red_lane};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  mbce_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .start_x     (in_tdata[11:0]),
    .start_y     (in_tdata[23:12]),
    .rect_width  (in_tdata[36:24]),
    .rect_height (in_tdata[49:37]),
    .color_fg    (in_tdata[73:50]),
    .color_bg    (in_tdata[97:74]),
    .pixel_bits  (in_tdata[105:98]),
    .item_valid  (f_valid),
    .item_ready  (f_ready),
    .item        (f_item)
  );

  mbce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  mbce_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .write_address (wr_address),
    .write_data    (wr_data),
    .byte_enable   (wr_en),
    .last          (out_tlast),
    .done_res      (out_tuser)
  );

  assign out_tdata = {4'd0, wr_en, wr_data, wr_address};

endmodule

// File: dv/tb_mono_bitmap_color_expand_blit.sv
// Self-checking testbench for the monochrome color-expansion blitter.
// Depends directly on rtl/mbce_pkg.sv and rtl/mono_bitmap_color_expand_blit.sv only.
// Drives start and bitmap items, predicts every pixel write and compares results.
module tb_mono_bitmap_color_expand_blit;
  timeunit 1ns;
  timeprecision 1ps;

  import mbce_pkg::*;

  // Idle cycles granted after the last pixel write before touching registers.
  localparam int SETTLE_CYCLES = 16;
  // Cycles without any transfer after which the run is declared hung.
  localparam int STALL_LIMIT   = 4000;
  // Random items per register setting.
  localparam int PHASE_ITEMS   = 48;
  // Mismatch lines printed before further reports are only counted.
  localparam int REPORT_CAP    = 100;

  typedef enum int {
    REG_BASE_ADDRESS    = 0,
    REG_LINE_PITCH      = 1,
    REG_BYTES_PER_PIXEL = 2,
    REG_BLUE_LANE       = 3,
    REG_GREEN_LANE      = 4,
    REG_RED_LANE        = 5
  } cfg_reg_t;

  // One item of the input stream, all fields present whatever the kind.
  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
    logic [COLOR_W-1:0] color_fg;
    logic [COLOR_W-1:0] color_bg;
    logic [7:0]         pixel_bits;
  } blit_item_t;

  // One pixel write of the result stream.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
    logic [3:0]        ben;
    logic              byte_last;
    logic              rect_done;
  } pixel_write_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // Block ports, all inputs known from time zero.
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata    = '0;
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [71:0]  out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [4:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  mono_bitmap_color_expand_blit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [ADDR_W-1:0] shadow_base  = '0;
  logic [15:0]       shadow_pitch = 16'd4096;
  logic [2:0]        shadow_bpp   = 3'd4;
  logic [1:0]        shadow_blue  = 2'd0;
  logic [1:0]        shadow_green = 2'd1;
  logic [1:0]        shadow_red   = 2'd2;

  // Predicted rectangle walker state.
  logic              rect_active = 1'b0;
  logic [DIM_W-1:0]  col_count   = '0;
  logic [DIM_W-1:0]  row_count   = '0;
  logic [ADDR_W-1:0] row_addr    = '0;
  logic [ADDR_W-1:0] pix_addr    = '0;
  logic [DIM_W-1:0]  saved_w     = '0;
  logic [DIM_W-1:0]  saved_h     = '0;
  logic [COLOR_W-1:0] saved_fg   = '0;
  logic [COLOR_W-1:0] saved_bg   = '0;

  blit_item_t   blit_items[$];
  pixel_write_t pending_pixels[$];
  blit_item_t   shown_item;

  int  send_idle_pct  = 26;
  int  recv_idle_pct  = 61;
  int  mismatch_count = 0;
  int  stall_cycles   = 0;
  // Whether the generated stream may have left a rectangle unfinished.
  bit  gen_open       = 1'b1;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Color bytes in their lanes; later lanes overwrite earlier ones.
  function automatic void place_color(input logic [COLOR_W-1:0] color,
                                      output logic [31:0] wdata, output logic [3:0] ben);
    wdata = '0;
    ben   = '0;
    wdata[{shadow_blue, 3'b000} +: 8]  = color[7:0];
    ben[shadow_blue]                   = 1'b1;
    wdata[{shadow_green, 3'b000} +: 8] = color[15:8];
    ben[shadow_green]                  = 1'b1;
    wdata[{shadow_red, 3'b000} +: 8]   = color[23:16];
    ben[shadow_red]                    = 1'b1;
  endfunction

  // Advance the walker by one accepted item and queue the pixel writes it yields.
  task automatic expand_item(input blit_item_t it);
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [COLOR_W-1:0] color;
    logic [31:0]        wdata;
    logic [3:0]         ben;
    logic               fin;
    pixel_write_t       px;
    if (it.op == OP_START) begin
      w = (it.rect_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : it.rect_width;
      h = (it.rect_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : it.rect_height;
      saved_w   = w;
      saved_h   = h;
      saved_fg  = it.color_fg;
      saved_bg  = it.color_bg;
      pix_addr  = shadow_base + 32'(shadow_pitch) * 32'(it.start_y)
                  + 32'(shadow_bpp) * 32'(it.start_x);
      row_addr  = pix_addr;
      col_count = '0;
      row_count = '0;
      rect_active = (w != '0) && (h != '0);
    end else if (rect_active) begin
      for (int k = 0; k < 8 && rect_active; k++) begin
        color = it.pixel_bits[7-k] ? saved_fg : saved_bg;
        place_color(color, wdata, ben);
        px.addr = pix_addr;
        px.data = wdata;
        px.ben  = ben;
        fin = 1'b0;
        col_count++;
        pix_addr += 32'(shadow_bpp);
        // End of a row: step down one pitch from the row start.
        if (col_count >= saved_w) begin
          col_count = '0;
          row_count++;
          row_addr += 32'(shadow_pitch);
          pix_addr = row_addr;
          if (row_count >= saved_h) begin
            fin = 1'b1;
            rect_active = 1'b0;
          end
        end
        px.byte_last = fin || (k == 7);
        px.rect_done = fin;
        pending_pixels.push_back(px);
      end
    end
  endtask

  function automatic logic [111:0] pack_item(input blit_item_t it);
    logic [111:0] v;
    v = '0;
    v[11:0]   = it.start_x;
    v[23:12]  = it.start_y;
    v[36:24]  = it.rect_width;
    v[49:37]  = it.rect_height;
    v[73:50]  = it.color_fg;
    v[97:74]  = it.color_bg;
    v[105:98] = it.pixel_bits;
    return v;
  endfunction

  // Unused fields of each kind carry random values so that they must be ignored.
  function automatic void push_start(input int x, input int y, input int w, input int h,
                                     input int fg, input int bg);
    blit_item_t it;
    it.op          = OP_START;
    it.start_x     = COORD_W'(x);
    it.start_y     = COORD_W'(y);
    it.rect_width  = DIM_W'(w);
    it.rect_height = DIM_W'(h);
    it.color_fg    = COLOR_W'(fg);
    it.color_bg    = COLOR_W'(bg);
    it.pixel_bits  = 8'($urandom);
    blit_items.push_back(it);
  endfunction

  function automatic void push_bits(input int b);
    blit_item_t it;
    it.op          = OP_BITMAP;
    it.start_x     = COORD_W'($urandom);
    it.start_y     = COORD_W'($urandom);
    it.rect_width  = DIM_W'($urandom);
    it.rect_height = DIM_W'($urandom);
    it.color_fg    = COLOR_W'($urandom);
    it.color_bg    = COLOR_W'($urandom);
    it.pixel_bits  = 8'(b);
    blit_items.push_back(it);
  endfunction

  // Input driver: present the next queued item once the previous transfer is done.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expand_item(shown_item);
      if (!in_tvalid || in_tready) begin
        if (blit_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_item = blit_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= pack_item(shown_item);
          in_tuser  <= shown_item.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each pixel write against the oldest prediction.
  always @(posedge clk) begin
    pixel_write_t got;
    pixel_write_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.addr      = out_tdata[31:0];
        got.data      = out_tdata[63:32];
        got.ben       = out_tdata[67:64];
        got.byte_last = out_tlast;
        got.rect_done = out_tuser;
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected write addr %h data %h be %h last %b done %b",
                                    got.addr, got.data, got.ben, got.byte_last, got.rect_done));
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "got addr %h data %h be %h last %b done %b, want %h %h %h %b %b",
              got.addr, got.data, got.ben, got.byte_last, got.rect_done,
              want.addr, want.data, want.ben, want.byte_last, want.rect_done));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("mono_bitmap_color_expand_blit verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(int'(idx) * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_BASE_ADDRESS:    shadow_base  = value;
      REG_LINE_PITCH:      shadow_pitch = value[15:0];
      REG_BYTES_PER_PIXEL: shadow_bpp   = value[2:0];
      REG_BLUE_LANE:       shadow_blue  = value[1:0];
      REG_GREEN_LANE:      shadow_green = value[1:0];
      default:             shadow_red   = value[1:0];
    endcase
  endtask

  // Wait until every item is taken and every pixel write seen, then let the
  // pipeline empty of items that yield nothing.
  task automatic wait_idle();
    while (blit_items.size() != 0 || in_tvalid || pending_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] base, input int pitch, input int bpp,
                           input int blue, input int green, input int red);
    wait_idle();
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_LINE_PITCH, 32'(pitch));
    write_reg(REG_BYTES_PER_PIXEL, 32'(bpp));
    write_reg(REG_BLUE_LANE, 32'(blue));
    write_reg(REG_GREEN_LANE, 32'(green));
    write_reg(REG_RED_LANE, 32'(red));
    @(negedge clk);
  endtask

  // Random register setting; the extreme form uses only boundary values.
  task automatic random_config(input bit extreme);
    if (extreme)
      configure($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, $urandom_range(1) ? 65535 : 0,
                $urandom_range(1) ? 7 : 0, $urandom_range(1) ? 3 : 0,
                $urandom_range(1) ? 3 : 0, $urandom_range(1) ? 3 : 0);
    else
      configure($urandom, $urandom_range(65535),
                ($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(7),
                $urandom_range(3), $urandom_range(3), $urandom_range(3));
  endtask

  // Mostly complete rectangles with random bitmaps, some cut short, some
  // empty, a few huge ones, and stray bytes while nothing is active.
  task automatic random_phase(input int target);
    int counted;
    int r;
    int w;
    int h;
    int need;
    int nbytes;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        if (!gen_open) push_bits($urandom_range(255));
      end else if (r < 14) begin
        if ($urandom_range(1)) begin
          w = 0;
          h = $urandom_range(8191);
        end else begin
          w = $urandom_range(8191);
          h = 0;
        end
        push_start($urandom, $urandom, w, h, $urandom, $urandom);
        counted++;
        gen_open = 1'b0;
        if ($urandom_range(1)) push_bits($urandom_range(255));
      end else begin
        if ($urandom_range(19) == 0) begin
          // Too large to finish here; left open until the next start.
          if ($urandom_range(1)) begin
            w = $urandom_range(8191, 4000);
            h = $urandom_range(8191, 1);
          end else begin
            w = $urandom_range(8191, 1);
            h = $urandom_range(8191, 4000);
          end
          nbytes   = $urandom_range(6, 1);
          gen_open = 1'b1;
        end else begin
          w    = $urandom_range(24, 1);
          h    = $urandom_range(6, 1);
          need = (w * h + 7) / 8;
          if ($urandom_range(99) < 85) begin
            nbytes   = need;
            gen_open = 1'b0;
          end else begin
            nbytes   = $urandom_range(need - 1, 0);
            gen_open = 1'b1;
          end
        end
        push_start($urandom, $urandom, w, h, $urandom, $urandom);
        counted++;
        repeat (nbytes) begin
          push_bits($urandom_range(255));
          counted++;
        end
        if (!gen_open && $urandom_range(3) == 0) push_bits($urandom_range(255));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: byte with no rectangle, rectangle ending
    // mid-byte, empty rectangle, clamped size abandoned by a new start.
    push_bits(8'hFF);
    push_start(0, 0, 3, 2, 24'hFFFFFF, 24'h000000);
    push_bits(8'hA5);
    push_bits(8'h00);
    push_start(4095, 4095, 0, 5, 24'h00FF00, 24'hFF00FF);
    push_bits(8'hFF);
    push_start(4095, 4095, 8191, 8191, 24'h123456, 24'hABCDEF);
    push_bits(8'hFF);
    push_bits(8'h00);
    push_start(1, 2, 2, 3, 24'h000000, 24'hFFFFFF);
    push_bits(8'h5A);

    // All lanes on one byte, largest pitch and pixel size, address wrap.
    configure(32'hFFFF_FFFF, 65535, 7, 3, 3, 3);
    push_start(4095, 4095, 1, 4096, 24'hFF00FF, 24'h00FF00);
    push_bits(8'h81);
    push_bits(8'h7E);
    push_start(0, 1, 8, 1, 24'hC0FFEE, 24'h0BADF0);
    push_bits(8'hC3);

    // Zero pitch and pixel size, green and blue sharing a lane.
    configure(32'h8000_0000, 0, 0, 1, 1, 2);
    push_start(100, 200, 13, 1, 24'h13579B, 24'h2468AC);
    push_bits(8'hF0);
    push_bits(8'h0F);

    // Byte-sized pixels with reversed lanes, single-pixel and full-size rectangles.
    configure(32'h0000_1000, 1, 1, 3, 2, 1);
    push_start(7, 9, 1, 1, 24'h808080, 24'h7F7F7F);
    push_bits(8'h80);
    push_start(0, 0, 4096, 4096, 24'hFEDCBA, 24'h012345);
    push_bits(8'hFF);

    // Random part under three idle patterns, two register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      for (int sub = 0; sub < 2; sub++) begin
        random_config(mode == 1 && sub == 1);
        send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 61 : 0;
        recv_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 26 : 0;
        random_phase(PHASE_ITEMS);
      end
    end

    wait_idle();
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixel writes never arrived", pending_pixels.size()));
    if (mismatch_count == 0) begin
      $display("mono_bitmap_color_expand_blit verification clean");
    end else begin
      $display("mono_bitmap_color_expand_blit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mbce_pkg.sv
rtl/mbce_front.sv
rtl/mbce_queue.sv
rtl/mbce_back.sv
rtl/mono_bitmap_color_expand_blit.sv
dv/tb_mono_bitmap_color_expand_blit.sv
